>>> hw/rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg: shared types and constants for the tilt average and tone block
// sizes, the arctangent table, sequencer states and tone codes
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

  // window and cordic depth
  localparam int unsigned Window      = 10;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned CordicIters =
      (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

  // field widths
  localparam int unsigned AccelW   = 16;
  localparam int unsigned StepW    = 16;
  localparam int unsigned AngleW   = 14;
  localparam int unsigned YawW     = 24;
  localparam int unsigned ToneW    = 8;
  localparam int unsigned RollSumW = 18;
  localparam int unsigned YawSumW  = 28;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ProdW    = AccelW + StepW + 1;

  // square root unit
  localparam int unsigned SqrtInW = 2 * AccelW;
  localparam int unsigned RootW   = AccelW;

  // cordic unit
  localparam int unsigned NumW     = AccelW + 1;
  localparam int unsigned PreShift = 8;
  localparam int unsigned CordW    = 27;
  localparam int unsigned ZW       = 23;
  localparam int unsigned AtanW    = 20;
  localparam int unsigned IdxW     = $clog2(AtanEntries);
  localparam int unsigned AngleMax = 5760;

  // divide by the window length through a reciprocal multiply
  // exact while magnitude times the reciprocal rounding error stays below 2^31
  localparam int unsigned     DivW       = YawSumW;
  localparam int unsigned     RecipW     = 32;
  localparam int unsigned     RecipShift = 31;
  localparam longint unsigned RecipMul   =
      ((64'd1 << RecipShift) + Window - 1) / Window;

  // tone durations
  localparam logic [ToneW-1:0] ToneLong  = ToneW'(200);
  localparam logic [ToneW-1:0] ToneMid   = ToneW'(100);
  localparam logic [ToneW-1:0] ToneShort = ToneW'(50);
  localparam logic [ToneW-1:0] ToneTick  = ToneW'(25);

  typedef enum logic [3:0] {
    SeqIdle,
    SeqLoad,
    SeqSqrtRoll,
    SeqCordRoll,
    SeqSqrtPitch,
    SeqCordPitch,
    SeqAccum,
    SeqDivStart,
    SeqDivWait,
    SeqEmit
  } tas_seq_e;

  typedef enum logic [2:0] {
    SqIdle,
    SqSquareA,
    SqSquareB,
    SqSum,
    SqIter
  } tas_sqrt_e;

  typedef enum logic [1:0] {
    CoIdle,
    CoIter,
    CoRound
  } tas_cordic_e;

  typedef enum logic [1:0] {
    DivRoll,
    DivPitch,
    DivYaw
  } tas_div_sel_e;

  // atan(2^-i) in 2^-14 degree
  function automatic logic [AtanW-1:0] atan_lut(input logic [IdxW-1:0] idx);
    logic [AtanW-1:0] val;
    unique case (idx)
      5'd0:    val = AtanW'(737280);
      5'd1:    val = AtanW'(435242);
      5'd2:    val = AtanW'(229970);
      5'd3:    val = AtanW'(116736);
      5'd4:    val = AtanW'(58595);
      5'd5:    val = AtanW'(29326);
      5'd6:    val = AtanW'(14667);
      5'd7:    val = AtanW'(7334);
      5'd8:    val = AtanW'(3667);
      5'd9:    val = AtanW'(1833);
      5'd10:   val = AtanW'(917);
      5'd11:   val = AtanW'(458);
      5'd12:   val = AtanW'(229);
      5'd13:   val = AtanW'(115);
      5'd14:   val = AtanW'(57);
      5'd15:   val = AtanW'(29);
      5'd16:   val = AtanW'(14);
      5'd17:   val = AtanW'(7);
      5'd18:   val = AtanW'(4);
      5'd19:   val = AtanW'(2);
      5'd20:   val = AtanW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tas_if.sv
// ----------------------------------------------------------------------------
// tas_if: request channels of the tilt average and tone block
// sample channel in, window result channel out, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tas_in_if;
  import tas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic signed [AccelW-1:0] yaw_rate;

  modport source (
    output valid, accel_x, accel_y, accel_z, yaw_rate,
    input  ready
  );

  modport sink (
    input  valid, accel_x, accel_y, accel_z, yaw_rate,
    output ready
  );
endinterface

interface tas_out_if;
  import tas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] avg_roll;
  logic signed [AngleW-1:0] avg_pitch;
  logic signed [YawW-1:0]   avg_yaw;
  logic [ToneW-1:0]         tone_duration;

  modport source (
    output valid, avg_roll, avg_pitch, avg_yaw, tone_duration,
    input  ready
  );

  modport sink (
    input  valid, avg_roll, avg_pitch, avg_yaw, tone_duration,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/tas_isqrt.sv
// ----------------------------------------------------------------------------
// tas_isqrt: iterative integer square root of a^2 + b^2
// squares through one multiplier, then one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tas_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tas_pkg::AccelW-1:0] a_i,
  input  logic signed [tas_pkg::AccelW-1:0] b_i,
  output logic                              done_o,
  output logic [tas_pkg::RootW-1:0]         root_o
);
  import tas_pkg::*;

  localparam logic [SqrtInW-1:0] BitStart = SqrtInW'(1) << (SqrtInW - 2);

  tas_sqrt_e state_q, state_d;
  logic      done_q;

  logic signed [AccelW-1:0]    a_q, b_q, sq_op;
  logic signed [SqrtInW-1:0]   sq;
  logic [SqrtInW-1:0]          p_q, v_q, r_q, bit_q;
  logic [SqrtInW:0]            trial;
  logic                        take;

  assign sq_op = (state_q == SqSquareA) ? a_q : b_q;
  assign sq    = sq_op * sq_op;
  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign take  = {1'b0, v_q} >= trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SqIdle:    if (start_i) state_d = SqSquareA;
      SqSquareA: state_d = SqSquareB;
      SqSquareB: state_d = SqSum;
      SqSum:     state_d = SqIter;
      SqIter:    if (bit_q[0]) state_d = SqIdle;
      default:   state_d = SqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SqIter) && bit_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SqIdle: begin
        if (start_i) begin
          a_q <= a_i;
          b_q <= b_i;
        end
      end
      SqSquareA: p_q <= $unsigned(sq);
      SqSquareB: begin
        v_q <= p_q;
        p_q <= $unsigned(sq);
      end
      SqSum: begin
        v_q   <= v_q + p_q;
        r_q   <= '0;
        bit_q <= BitStart;
      end
      SqIter: begin
        if (take) begin
          v_q <= v_q - trial[SqrtInW-1:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/tas_cordic.sv
// ----------------------------------------------------------------------------
// tas_cordic: vectoring cordic for the angle of (den, num)
// one micro-rotation per cycle, then rounding to 1/64 degree and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module tas_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tas_pkg::NumW-1:0]   num_i,
  input  logic [tas_pkg::RootW-1:0]         den_i,
  output logic                              done_o,
  output logic signed [tas_pkg::AngleW-1:0] angle_o
);
  import tas_pkg::*;

  localparam logic [IdxW-1:0]         LastIdx  = IdxW'(CordicIters - 1);
  localparam logic signed [ZW-1:0]    ZMax     = ZW'(AngleMax);
  localparam logic signed [ZW-1:0]    ZMin     = -ZW'(AngleMax);
  localparam logic signed [ZW-1:0]    RoundAdd = ZW'(128);
  localparam logic signed [AngleW-1:0] AMax    = AngleW'(AngleMax);

  tas_cordic_e state_q, state_d;
  logic        done_q;

  logic signed [CordW-1:0]  x_q, y_q, xs, ys;
  logic signed [ZW-1:0]     z_q, zr;
  logic [IdxW-1:0]          i_q;
  logic                     zero_q;
  logic signed [AngleW-1:0] angle_q, angle_n;
  logic [ZW-1:0]            atan_ext;

  assign xs       = x_q >>> i_q;
  assign ys       = y_q >>> i_q;
  assign atan_ext = {{(ZW - AtanW){1'b0}}, atan_lut(i_q)};
  assign zr       = (z_q + RoundAdd) >>> 8;

  always_comb begin
    if (zero_q) begin
      if (y_q == '0)        angle_n = '0;
      else if (y_q[CordW-1]) angle_n = -AMax;
      else                   angle_n = AMax;
    end else if (zr > ZMax) begin
      angle_n = AMax;
    end else if (zr < ZMin) begin
      angle_n = -AMax;
    end else begin
      angle_n = zr[AngleW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CoIdle:  if (start_i) state_d = (den_i == '0) ? CoRound : CoIter;
      CoIter:  if (i_q == LastIdx) state_d = CoRound;
      CoRound: state_d = CoIdle;
      default: state_d = CoIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CoRound);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CoIdle: begin
        if (start_i) begin
          x_q    <= {{(CordW - RootW - PreShift){1'b0}}, den_i, {PreShift{1'b0}}};
          y_q    <= {{(CordW - NumW - PreShift){num_i[NumW-1]}}, num_i,
                     {PreShift{1'b0}}};
          z_q    <= '0;
          i_q    <= '0;
          zero_q <= (den_i == '0);
        end
      end
      CoIter: begin
        // rotate toward the x axis
        if (!y_q[CordW-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + $signed(atan_ext);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - $signed(atan_ext);
        end
        i_q <= i_q + 1'b1;
      end
      CoRound: angle_q <= angle_n;
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

>>> hw/rtl/tas_div.sv
// ----------------------------------------------------------------------------
// tas_div: division of a magnitude by the window length
// one reciprocal multiply, quotient registered and ready the cycle after start
// ----------------------------------------------------------------------------
`default_nettype none

module tas_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tas_pkg::DivW-1:0]   dvd_i,
  output logic                       done_o,
  output logic [tas_pkg::DivW-1:0]   quo_o
);
  import tas_pkg::*;

  localparam logic [RecipW-1:0] RecipVal = RecipW'(RecipMul);

  logic                     done_q;
  logic [DivW-1:0]          quo_q;
  logic [DivW+RecipW-1:0]   prod;

  assign prod = dvd_i * RecipVal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= prod[RecipShift +: DivW];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/tilt_average_tone_select.sv
// ----------------------------------------------------------------------------
// tilt_average_tone_select: accelerometer tilt, yaw integration, averaging
// roll and pitch per sample, window averages and a tone duration per window
// ----------------------------------------------------------------------------
// per sample, from acceptance to ready again: two square root passes and
//   two cordic passes
// the sample that closes a window adds three reciprocal divides and one
//   result load, plus any wait on a held result
// throughput: one sample per pass, ready only while the sequencer is idle
// reset: sequencer, handshakes, sums, count and yaw angle clear at once,
//   step_scale returns to 6554; no clearing pass
`default_nettype none

module tilt_average_tone_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tas_in_if.sink                       in_if,
  tas_out_if.source                    out_if,
  input  logic                         cfg_we_i,
  input  logic [tas_pkg::StepW-1:0]    cfg_data_i
);
  import tas_pkg::*;

  localparam logic [StepW-1:0]  StepReset = StepW'(6554);
  localparam logic [CountW-1:0] CntLast   = CountW'(Window - 1);
  localparam logic signed [ProdW:0] YawRound = (ProdW + 1)'(8192);

  // sequencer
  tas_seq_e     state_q, state_d;
  tas_div_sel_e sel_q;

  logic sqrt_start, sqrt_done;
  logic cord_start, cord_done;
  logic div_start, div_done;
  logic load_out;

  // configuration
  logic [StepW-1:0] step_q;

  // latched sample
  logic signed [AccelW-1:0] ax_q, ay_q, az_q, rate_q;
  logic signed [ProdW-1:0]  prod_q;

  // per-sample results and window state
  logic signed [AngleW-1:0]   roll_q, pitch_q;
  logic signed [YawW-1:0]     yaw_q;
  logic signed [RollSumW-1:0] roll_sum_q, pitch_sum_q;
  logic signed [YawSumW-1:0]  yaw_sum_q;
  logic [CountW-1:0]          cnt_q;

  // window averages
  logic signed [AngleW-1:0] avg_roll_q, avg_pitch_q;
  logic signed [YawW-1:0]   avg_yaw_q;

  // output register
  logic                     out_valid_q;
  logic signed [AngleW-1:0] out_roll_q, out_pitch_q;
  logic signed [YawW-1:0]   out_yaw_q;
  logic [ToneW-1:0]         out_tone_q;

  // shared unit operands
  logic signed [AccelW-1:0] sqrt_a;
  logic [RootW-1:0]         root;
  logic signed [NumW-1:0]   cord_num;
  logic signed [AngleW-1:0] angle;

  // yaw step
  logic signed [ProdW:0]  yaw_rnd, yaw_inc;
  logic signed [YawW:0]   yaw_wide;
  logic signed [YawW-1:0] yaw_new;

  // divider operands
  logic signed [DivW-1:0] div_val, div_res;
  logic [DivW-1:0]        div_mag, quo;
  logic                   div_neg_q;

  // tone selection
  logic [AngleW-1:0]   roll_abs;
  logic [AngleW-7:0]   roll_deg;
  logic [ToneW-1:0]    tone;

  // ---------------------------------------------------------------- units
  // roll first uses (ax, az), pitch then (ay, az)
  assign sqrt_a = (state_q == SeqLoad) ? ax_q : ay_q;

  tas_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .a_i     (sqrt_a),
    .b_i     (az_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // roll numerator is ay, pitch numerator is -ax
  assign cord_num = (state_q == SeqSqrtRoll) ? {ay_q[AccelW-1], ay_q}
                                             : -{ax_q[AccelW-1], ax_q};

  tas_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .num_i   (cord_num),
    .den_i   (root),
    .done_o  (cord_done),
    .angle_o (angle)
  );

  always_comb begin
    unique case (sel_q)
      DivRoll:  div_val = {{(DivW - RollSumW){roll_sum_q[RollSumW-1]}}, roll_sum_q};
      DivPitch: div_val = {{(DivW - RollSumW){pitch_sum_q[RollSumW-1]}}, pitch_sum_q};
      DivYaw:   div_val = yaw_sum_q;
      default:  div_val = '0;
    endcase
  end

  // divide the magnitude, restore the sign: truncation toward zero
  assign div_mag = div_val[DivW-1] ? $unsigned(-div_val) : $unsigned(div_val);
  assign div_res = div_neg_q ? -$signed(quo) : $signed(quo);

  tas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_mag),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ---------------------------------------------------------------- yaw
  // increment = floor((rate * step + 8192) / 16384), then saturate
  assign yaw_rnd  = {prod_q[ProdW-1], prod_q} + YawRound;
  assign yaw_inc  = yaw_rnd >>> 14;
  assign yaw_wide = {yaw_q[YawW-1], yaw_q} + yaw_inc[YawW:0];

  always_comb begin
    if (yaw_wide[YawW] != yaw_wide[YawW-1]) begin
      yaw_new = yaw_wide[YawW] ? {1'b1, {(YawW - 1){1'b0}}}
                               : {1'b0, {(YawW - 1){1'b1}}};
    end else begin
      yaw_new = yaw_wide[YawW-1:0];
    end
  end

  // ---------------------------------------------------------------- tone
  // whole degrees of the average roll pick the duration
  assign roll_abs = avg_roll_q[AngleW-1] ? $unsigned(-avg_roll_q)
                                         : $unsigned(avg_roll_q);
  assign roll_deg = roll_abs[AngleW-1:6];

  always_comb begin
    if (roll_deg >= (AngleW - 6)'(3))      tone = ToneLong;
    else if (roll_deg == (AngleW - 6)'(2)) tone = ToneMid;
    else if (roll_deg == (AngleW - 6)'(1)) tone = ToneShort;
    else                                   tone = ToneTick;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      SeqIdle: begin
        if (in_if.valid) state_d = SeqLoad;
      end
      SeqLoad: begin
        sqrt_start = 1'b1;
        state_d    = SeqSqrtRoll;
      end
      SeqSqrtRoll: begin
        if (sqrt_done) begin
          cord_start = 1'b1;
          state_d    = SeqCordRoll;
        end
      end
      SeqCordRoll: begin
        if (cord_done) begin
          sqrt_start = 1'b1;
          state_d    = SeqSqrtPitch;
        end
      end
      SeqSqrtPitch: begin
        if (sqrt_done) begin
          cord_start = 1'b1;
          state_d    = SeqCordPitch;
        end
      end
      SeqCordPitch: begin
        if (cord_done) state_d = SeqAccum;
      end
      SeqAccum: begin
        state_d = (cnt_q == CntLast) ? SeqDivStart : SeqIdle;
      end
      SeqDivStart: begin
        div_start = 1'b1;
        state_d   = SeqDivWait;
      end
      SeqDivWait: begin
        if (div_done) state_d = (sel_q == DivYaw) ? SeqEmit : SeqDivStart;
      end
      SeqEmit: begin
        // wait for the output register to free up
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      step_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q       <= '0;
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
      yaw_sum_q   <= '0;
      cnt_q       <= '0;
      sel_q       <= DivRoll;
    end else begin
      unique case (state_q)
        SeqAccum: begin
          // yaw updates first, the new yaw goes into its sum
          yaw_q       <= yaw_new;
          roll_sum_q  <= roll_sum_q +
                         {{(RollSumW - AngleW){roll_q[AngleW-1]}}, roll_q};
          pitch_sum_q <= pitch_sum_q +
                         {{(RollSumW - AngleW){pitch_q[AngleW-1]}}, pitch_q};
          yaw_sum_q   <= yaw_sum_q + {{(YawSumW - YawW){yaw_new[YawW-1]}}, yaw_new};
          cnt_q       <= cnt_q + 1'b1;
          sel_q       <= DivRoll;
        end
        SeqDivWait: begin
          if (div_done) begin
            unique case (sel_q)
              DivRoll:  sel_q <= DivPitch;
              DivPitch: sel_q <= DivYaw;
              default:  sel_q <= DivRoll;
            endcase
          end
        end
        SeqEmit: begin
          if (load_out) begin
            roll_sum_q  <= '0;
            pitch_sum_q <= '0;
            yaw_sum_q   <= '0;
            cnt_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (state_q == SeqIdle && in_if.valid) begin
      ax_q   <= in_if.accel_x;
      ay_q   <= in_if.accel_y;
      az_q   <= in_if.accel_z;
      rate_q <= in_if.yaw_rate;
    end
    if (state_q == SeqLoad) begin
      prod_q <= rate_q * $signed({1'b0, step_q});
    end
    if (state_q == SeqCordRoll && cord_done) begin
      roll_q <= angle;
    end
    if (state_q == SeqCordPitch && cord_done) begin
      pitch_q <= angle;
    end
    if (div_start) begin
      div_neg_q <= div_val[DivW-1];
    end
    if (state_q == SeqDivWait && div_done) begin
      unique case (sel_q)
        DivRoll:  avg_roll_q  <= div_res[AngleW-1:0];
        DivPitch: avg_pitch_q <= div_res[AngleW-1:0];
        DivYaw:   avg_yaw_q   <= div_res[YawW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_roll_q  <= avg_roll_q;
      out_pitch_q <= avg_pitch_q;
      out_yaw_q   <= avg_yaw_q;
      out_tone_q  <= tone;
    end
  end

  assign in_if.ready          = (state_q == SeqIdle);
  assign out_if.valid         = out_valid_q;
  assign out_if.avg_roll      = out_roll_q;
  assign out_if.avg_pitch     = out_pitch_q;
  assign out_if.avg_yaw       = out_yaw_q;
  assign out_if.tone_duration = out_tone_q;

endmodule

`default_nettype wire

>>> hw/rtl/tas_checker.sv
// ----------------------------------------------------------------------------
// tas_checker: port-level checks for the tilt average and tone block
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tas_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [tas_pkg::AngleW-1:0] avg_roll_i,
  input logic [tas_pkg::ToneW-1:0]         tone_duration_i
);
  import tas_pkg::*;

  localparam logic signed [AngleW-1:0] LongPos = AngleW'(192);
  localparam logic signed [AngleW-1:0] LongNeg = -AngleW'(192);

  // input ready drops in the cycle after an accepted sample
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(avg_roll_i) && $stable(tone_duration_i))
    else $error("result payload changed while stalled");

  a_tone_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tone_duration_i == ToneLong || tone_duration_i == ToneMid ||
                    tone_duration_i == ToneShort || tone_duration_i == ToneTick)
    else $error("tone duration not a legal duration");

  // three degrees or more of average roll gives the long tone
  a_tone_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (avg_roll_i >= LongPos || avg_roll_i <= LongNeg)
    |-> tone_duration_i == ToneLong)
    else $error("tone duration does not match average roll");

endmodule

bind tilt_average_tone_select tas_checker u_tas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .avg_roll_i      (out_if.avg_roll),
  .tone_duration_i (out_if.tone_duration)
);

`default_nettype wire

>>> test/tilt_average_tone_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_average_tone_select_tb: self-checking bench for the tilt average block
// drives accelerometer and yaw rate samples with bursty valid, stalls the
// window result channel, predicts every window average and tone duration
// in a cycle-free model and compares results in order, field by field
// ----------------------------------------------------------------------------

module tilt_average_tone_select_tb;
  import tas_pkg::*;

  // timing and run control
  localparam int SettleCycles   = 250;    // block busy after a sample with no result
  localparam int IdleLimit      = 12000;  // cycles with no request moving on any port
  localparam int LongHoldCycles = 2000;   // one long output back-pressure stretch
  localparam int LongHoldAfter  = 66;     // start it once this many windows came back

  localparam longint AngleLim = longint'(AngleMax);
  localparam longint YawTop   = 64'sd8388607;
  localparam longint YawBot   = -64'sd8388608;

  // atan(2^-i) in 2^-14 degree, rounded
  localparam longint AtanDeg14 [24] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  // how the yaw rate of a random batch is chosen
  typedef enum int {
    RateRandom,
    RateMax,
    RateMin
  } rate_mode_e;

  // output side back-pressure patterns
  typedef enum int {
    RxOpen,
    RxRandom,
    RxRuns
  } rx_mode_e;

  typedef struct {
    logic signed [AccelW-1:0] ax;
    logic signed [AccelW-1:0] ay;
    logic signed [AccelW-1:0] az;
    logic signed [AccelW-1:0] rate;
  } imu_sample_t;

  typedef struct {
    logic signed [AngleW-1:0] roll;
    logic signed [AngleW-1:0] pitch;
    logic signed [YawW-1:0]   yaw;
    logic [ToneW-1:0]         tone;
  } window_avg_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [StepW-1:0]  cfg_data_i;

  tas_in_if  sample_bus ();
  tas_out_if window_bus ();

  tilt_average_tone_select DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (sample_bus),
    .out_if     (window_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // samples waiting to be offered, and window results still owed by the block
  imu_sample_t pending_samples [$];
  window_avg_t window_avg_q [$];

  int errors;
  int samples_sent;
  int results_seen;
  int settings_used;
  int yaw_sat_samples;
  int tone_hits [4];

  // tilt model state, owned by the monitor process
  logic [StepW-1:0] step_model;
  longint           yaw_model;
  longint           roll_acc;
  longint           pitch_acc;
  longint           yaw_acc;
  int               window_fill;

  logic in_taken;

  // sender burst state
  int burst_left;
  int gap_left;

  // receiver pattern state
  rx_mode_e rx_mode;
  int       mode_left;
  int       run_left;
  logic     run_ready;
  int       hold_left;
  logic     long_hold_done;

  int idle_cycles;

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // exact floor square root
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 32;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // vectoring cordic angle of (den, num), den >= 0, in 1/64 degree
  function automatic longint tilt_64th(input longint num, input longint den);
    longint x;
    longint y;
    longint z;
    longint xn;
    if (den == 0) begin
      // vertical vector: straight up, straight down, or nothing at all
      return (num > 0) ? AngleLim : ((num < 0) ? -AngleLim : 0);
    end
    x = den * 256;
    y = num * 256;
    z = 0;
    for (int i = 0; i < CordicIters; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanDeg14[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanDeg14[i];
      end
      x = xn;
    end
    z = (z + 128) >>> 8;
    if (z > AngleLim) z = AngleLim;
    if (z < -AngleLim) z = -AngleLim;
    return z;
  endfunction

  function automatic logic signed [AccelW-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return AccelW'($urandom());
    endcase
  endfunction

  task automatic push_sample(input int ax, input int ay, input int az, input int rate);
    imu_sample_t s;
    s.ax   = AccelW'(ax);
    s.ay   = AccelW'(ay);
    s.az   = AccelW'(az);
    s.rate = AccelW'(rate);
    pending_samples.push_back(s);
  endtask

  // random samples, styled per window: noise, a steady small tilt, or corners
  task automatic queue_random(input int count, input rate_mode_e rate_mode);
    imu_sample_t s;
    int style;
    int base_ay;
    int az_mag;
    for (int k = 0; k < count; k++) begin
      if (k % Window == 0) begin
        style   = $urandom_range(0, 19);
        base_ay = $urandom_range(0, 900);
        if ($urandom_range(0, 1) != 0) base_ay = -base_ay;
        az_mag  = $urandom_range(6000, 16000);
      end
      if (style < 8) begin
        s.ax = AccelW'($urandom());
        s.ay = AccelW'($urandom());
        s.az = AccelW'($urandom());
      end else if (style < 17) begin
        // near level, so the average roll lands in every tone bucket
        s.ax = AccelW'(int'($urandom_range(0, 600)) - 300);
        s.ay = AccelW'(base_ay + int'($urandom_range(0, 40)) - 20);
        s.az = AccelW'(($urandom_range(0, 1) != 0) ? az_mag : -az_mag);
      end else begin
        s.ax = corner_value();
        s.ay = corner_value();
        s.az = corner_value();
      end
      case (rate_mode)
        RateMax: s.rate = 16'sh7fff;
        RateMin: s.rate = 16'sh8000;
        default: s.rate = (style >= 17) ? corner_value() : AccelW'($urandom());
      endcase
      pending_samples.push_back(s);
    end
  endtask

  // sender waits until every owed window is back and the block is quiet
  task automatic wait_idle();
    while (pending_samples.size() != 0 || sample_bus.valid || window_avg_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_step(input logic [StepW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // sender: one request per accepted sample, bursts with random gaps
  always @(negedge clk_i) begin
    logic        next_valid;
    imu_sample_t s;
    if (rst_ni) begin
      next_valid = sample_bus.valid && !in_taken;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          sample_bus.accel_x  <= s.ax;
          sample_bus.accel_y  <= s.ay;
          sample_bus.accel_z  <= s.az;
          sample_bus.yaw_rate <= s.rate;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a long gap-free stretch now and then
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      sample_bus.valid <= next_valid;
    end
  end

  // receiver: random stall pattern plus a single long hold
  always @(negedge clk_i) begin
    logic rdy;
    if (rst_ni) begin
      if (!long_hold_done && results_seen >= LongHoldAfter) begin
        hold_left      = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RxOpen:   rdy = 1'b1;
          RxRandom: rdy = ($urandom_range(0, 3) != 0);
          default: begin
            if (run_left == 0) begin
              run_ready = !run_ready;
              run_left  = $urandom_range(1, 20);
            end else begin
              run_left--;
            end
            rdy = run_ready;
          end
        endcase
      end
      window_bus.ready <= rdy;
    end
  end

  // monitor: checks window results, then folds each accepted sample into the model
  always @(posedge clk_i) begin
    window_avg_t      want;
    window_avg_t      want_new;
    longint           ax;
    longint           ay;
    longint           az;
    longint           rate;
    longint           roll;
    longint           pitch;
    longint           ar;
    longint           ap;
    longint           aw;
    longint           deg;
    longint unsigned  dr;
    longint unsigned  dp;
    if (!rst_ni) begin
      step_model  = StepW'(6554);
      yaw_model   = 0;
      roll_acc    = 0;
      pitch_acc   = 0;
      yaw_acc     = 0;
      window_fill = 0;
      in_taken   <= 1'b0;
    end else begin
      if (cfg_we_i) step_model = cfg_data_i;

      if (window_bus.valid && window_bus.ready) begin
        results_seen++;
        if (window_avg_q.size() == 0) begin
          report_mismatch($sformatf("window result with nothing owed: roll %0d pitch %0d",
                                    window_bus.avg_roll, window_bus.avg_pitch));
        end else begin
          want = window_avg_q.pop_front();
          if (window_bus.avg_roll !== want.roll)
            report_mismatch($sformatf("avg_roll got %0d want %0d",
                                      window_bus.avg_roll, want.roll));
          if (window_bus.avg_pitch !== want.pitch)
            report_mismatch($sformatf("avg_pitch got %0d want %0d",
                                      window_bus.avg_pitch, want.pitch));
          if (window_bus.avg_yaw !== want.yaw)
            report_mismatch($sformatf("avg_yaw got %0d want %0d",
                                      window_bus.avg_yaw, want.yaw));
          if (window_bus.tone_duration !== want.tone)
            report_mismatch($sformatf("tone_duration got %0d want %0d",
                                      window_bus.tone_duration, want.tone));
        end
      end

      in_taken <= sample_bus.valid && sample_bus.ready;
      if (sample_bus.valid && sample_bus.ready) begin
        samples_sent++;
        ax   = longint'(sample_bus.accel_x);
        ay   = longint'(sample_bus.accel_y);
        az   = longint'(sample_bus.accel_z);
        rate = longint'(sample_bus.yaw_rate);

        // roll from y over the x-z magnitude, pitch from -x over the y-z magnitude
        dr    = floor_sqrt(longint'(ax * ax + az * az));
        dp    = floor_sqrt(longint'(ay * ay + az * az));
        roll  = tilt_64th(ay, longint'(dr));
        pitch = tilt_64th(-ax, longint'(dp));

        // yaw integrates first and saturates, then everything goes into the sums
        yaw_model += (rate * longint'(step_model) + 8192) >>> 14;
        if (yaw_model >= YawTop) begin
          yaw_model = YawTop;
          yaw_sat_samples++;
        end
        if (yaw_model <= YawBot) begin
          yaw_model = YawBot;
          yaw_sat_samples++;
        end
        roll_acc  += roll;
        pitch_acc += pitch;
        yaw_acc   += yaw_model;
        window_fill++;

        if (window_fill == Window) begin
          // signed division, truncation toward zero
          ar  = roll_acc / longint'(Window);
          ap  = pitch_acc / longint'(Window);
          aw  = yaw_acc / longint'(Window);
          deg = ((ar < 0) ? -ar : ar) / 64;
          want_new.roll  = AngleW'(ar);
          want_new.pitch = AngleW'(ap);
          want_new.yaw   = YawW'(aw);
          if (deg >= 3) begin
            want_new.tone = ToneLong;
            tone_hits[0]++;
          end else if (deg == 2) begin
            want_new.tone = ToneMid;
            tone_hits[1]++;
          end else if (deg == 1) begin
            want_new.tone = ToneShort;
            tone_hits[2]++;
          end else begin
            want_new.tone = ToneTick;
            tone_hits[3]++;
          end
          window_avg_q.push_back(want_new);
          roll_acc    = 0;
          pitch_acc   = 0;
          yaw_acc     = 0;
          window_fill = 0;
        end
      end
    end
  end

  // watchdog: no request moving anywhere for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (sample_bus.valid && sample_bus.ready) ||
        (window_bus.valid && window_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no request moved in %0d cycles", IdleLimit);
      $display("tilt_average_tone_select_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // every block input known from the first instant
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_data_i          = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.accel_x  = '0;
    sample_bus.accel_y  = '0;
    sample_bus.accel_z  = '0;
    sample_bus.yaw_rate = '0;
    window_bus.ready    = 1'b0;
    errors          = 0;
    samples_sent    = 0;
    results_seen    = 0;
    settings_used   = 1;
    yaw_sat_samples = 0;
    tone_hits       = '{0, 0, 0, 0};
    burst_left      = 0;
    gap_left        = 0;
    rx_mode         = RxOpen;
    mode_left       = 0;
    run_left        = 0;
    run_ready       = 1'b1;
    hold_left       = 0;
    long_hold_done  = 1'b0;
    idle_cycles     = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed window: zero denominators, field extremes, yaw rate extremes
    push_sample(0, 0, 0, 0);                 // nothing anywhere: both angles zero
    push_sample(0, 32767, 0, 32767);         // roll straight up
    push_sample(0, -32768, 0, -32768);       // roll straight down
    push_sample(-32768, 0, 0, 0);            // pitch up from the most negative x
    push_sample(32767, 0, 0, 0);             // pitch down
    push_sample(32767, 32767, 32767, 32767);
    push_sample(-32768, -32768, -32768, -32768);
    push_sample(0, 0, 32767, 1);
    push_sample(0, 0, -32768, -1);           // upside down
    push_sample(-1, 1, -1, 0);
    // steady 1.5 degree roll, then the start of a -2.5 degree window
    for (int k = 0; k < 10; k++) push_sample(0, 262, 10000, 16);
    for (int k = 0; k < 5; k++) push_sample(0, -437, 10000, -16);
    queue_random(205, RateRandom);
    wait_idle();

    // no yaw integration at all
    set_step('0);
    queue_random(120, RateRandom);
    wait_idle();

    // largest step: drive yaw into both saturation limits
    set_step('1);
    queue_random(80, RateMax);
    queue_random(140, RateMin);
    queue_random(60, RateRandom);
    wait_idle();

    // random step, the long output hold falls in here
    set_step(StepW'($urandom_range(1, 65534)));
    queue_random(200, RateRandom);
    wait_idle();

    // smallest nonzero step
    set_step(StepW'(1));
    queue_random(80, RateRandom);
    wait_idle();

    if (window_avg_q.size() != 0)
      report_mismatch($sformatf("%0d window results never came", window_avg_q.size()));

    $display("run: %0d samples over %0d step_scale settings, %0d windows checked",
             samples_sent, settings_used, results_seen);
    $display("run: tone 200/100/50/25 windows %0d/%0d/%0d/%0d, %0d yaw-saturated samples",
             tone_hits[0], tone_hits[1], tone_hits[2], tone_hits[3], yaw_sat_samples);
    if (errors == 0) begin
      $display("tilt_average_tone_select_tb: clean");
    end else begin
      $display("tilt_average_tone_select_tb: errors");
    end
    $finish;
  end

endmodule
